[hdl/md4_pkg.sv]
// Shared types, constants and step functions for the MD4 digest engine.
// No dependencies; every other file in hdl/ imports this package.
package md4_pkg;

  localparam int FIFO_DEPTH = 4;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [31:0] K_ROUND2 = 32'h5A827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ED9EBA1;

  localparam logic [7:0]  PAD_BYTE     = 8'h80;
  localparam logic [3:0]  LEN_WORD_IDX = 4'd14;
  localparam logic [5:0]  LAST_STEP    = 6'd47;
  localparam logic [3:0]  LAST_LOAD    = 4'd15;
  localparam logic [2:0]  MAX_BYTES    = 3'd4;
  localparam logic [1:0]  LAST_DIGEST  = 2'd3;

  // One queued message word; last_blk marks the length word that closes the message.
  typedef struct packed {
    logic [31:0] data;
    logic        last_blk;
  } md4_word_t;

  typedef enum logic [2:0] {
    F_DATA,
    F_PAD,
    F_ZERO,
    F_LEN_LO,
    F_LEN_HI
  } front_state_t;

  typedef enum logic [1:0] {
    B_RUN,
    B_ADD,
    B_OUT
  } back_state_t;

  function automatic logic [31:0] iv_word(input logic [1:0] idx);
    logic [31:0] v;
    case (idx)
      2'd0:    v = IV_A;
      2'd1:    v = IV_B;
      2'd2:    v = IV_C;
      default: v = IV_D;
    endcase
    return v;
  endfunction

  // Message word used by a step: in order, then transposed, then bit-reversed.
  function automatic logic [3:0] msg_index(input logic [5:0] step);
    logic [3:0] v;
    case (step[5:4])
      2'd0:    v = step[3:0];
      2'd1:    v = {step[1:0], step[3:2]};
      default: v = {step[0], step[1], step[2], step[3]};
    endcase
    return v;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] step);
    logic [4:0] v;
    case ({step[5:4], step[1:0]})
      4'b0000: v = 5'd3;
      4'b0001: v = 5'd7;
      4'b0010: v = 5'd11;
      4'b0011: v = 5'd19;
      4'b0100: v = 5'd3;
      4'b0101: v = 5'd5;
      4'b0110: v = 5'd9;
      4'b0111: v = 5'd13;
      4'b1000: v = 5'd3;
      4'b1001: v = 5'd9;
      4'b1010: v = 5'd11;
      default: v = 5'd15;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_fn(input logic [5:0] step, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] v;
    case (step[5:4])
      2'd0:    v = (b & c) | (~b & d);
      2'd1:    v = (b & c) | (b & d) | (c & d);
      default: v = b ^ c ^ d;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] step);
    logic [31:0] v;
    case (step[5:4])
      2'd0:    v = 32'd0;
      2'd1:    v = K_ROUND2;
      default: v = K_ROUND3;
    endcase
    return v;
  endfunction

  // Amount is never zero here, so the right shift stays below 32.
  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    return (x << s) | (x >> (6'd32 - {1'b0, s}));
  endfunction

endpackage

[hdl/md4_fifo.sv]
// Small word queue between the MD4 front end and the compression core.
// Depends on md4_pkg for the queued word type.
module md4_fifo import md4_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  md4_word_t push_word,
  output logic      full,
  input  logic      pop,
  output md4_word_t head,
  output logic      not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  md4_word_t     mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[hdl/md4_front.sv]
// Front end of the MD4 engine: packs input bytes into 32-bit words, counts the
// message length and generates padding and length words. Depends on md4_pkg.
module md4_front import md4_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_item,
  output logic        push,
  output md4_word_t   push_word,
  input  logic        fifo_full
);

  front_state_t state_r, state_nxt;
  logic [23:0]  hold_r, hold_nxt;
  logic [1:0]   hold_cnt_r, hold_cnt_nxt;
  logic [63:0]  len_r, len_nxt;
  logic [3:0]   idx_r, idx_nxt;

  logic [2:0]   cnt_c;
  logic [31:0]  masked;
  logic [55:0]  packed_bytes;
  logic [2:0]   total;
  logic [64:0]  len_sum;
  logic [31:0]  pad_word;
  logic         accept;

  always_comb begin
    cnt_c = (in_byte_count > MAX_BYTES) ? MAX_BYTES : in_byte_count;
    for (int i = 0; i < 4; i++) begin
      masked[8*i +: 8] = (3'(i) < cnt_c) ? in_data_word[8*i +: 8] : 8'd0;
    end
    packed_bytes = {32'd0, hold_r} | ({24'd0, masked} << {hold_cnt_r, 3'b000});
    total        = {1'b0, hold_cnt_r} + cnt_c;
    len_sum      = {1'b0, len_r} + {59'd0, cnt_c, 3'b000};
    pad_word     = {8'd0, hold_r} | ({24'd0, PAD_BYTE} << {hold_cnt_r, 3'b000});
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    hold_nxt     = hold_r;
    hold_cnt_nxt = hold_cnt_r;
    len_nxt      = len_r;
    in_ready     = 1'b0;
    push         = 1'b0;
    push_word    = '{data: 32'd0, last_blk: 1'b0};
    case (state_r)
      F_DATA: begin
        in_ready = !fifo_full;
        if (accept) begin
          len_nxt = len_sum[64] ? '1 : len_sum[63:0];
          if (total >= 3'd4) begin
            push           = 1'b1;
            push_word.data = packed_bytes[31:0];
            hold_nxt       = packed_bytes[55:32];
            hold_cnt_nxt   = 2'(total - 3'd4);
          end else begin
            hold_nxt     = packed_bytes[23:0];
            hold_cnt_nxt = 2'(total);
          end
          if (in_last_item) begin
            state_nxt = F_PAD;
          end
        end
      end
      F_PAD: begin
        if (!fifo_full) begin
          push           = 1'b1;
          push_word.data = pad_word;
          hold_nxt       = '0;
          hold_cnt_nxt   = '0;
          state_nxt      = (idx_r == LEN_WORD_IDX - 4'd1) ? F_LEN_LO : F_ZERO;
        end
      end
      F_ZERO: begin
        if (!fifo_full) begin
          push = 1'b1;
          if (idx_r == LEN_WORD_IDX - 4'd1) begin
            state_nxt = F_LEN_LO;
          end
        end
      end
      F_LEN_LO: begin
        if (!fifo_full) begin
          push           = 1'b1;
          push_word.data = len_r[31:0];
          state_nxt      = F_LEN_HI;
        end
      end
      F_LEN_HI: begin
        if (!fifo_full) begin
          push               = 1'b1;
          push_word.data     = len_r[63:32];
          push_word.last_blk = 1'b1;
          len_nxt            = '0;
          state_nxt          = F_DATA;
        end
      end
      default: begin
        state_nxt = F_DATA;
      end
    endcase
    idx_nxt = push ? idx_r + 4'd1 : idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_DATA;
      hold_r     <= '0;
      hold_cnt_r <= '0;
      len_r      <= '0;
      idx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      hold_r     <= hold_nxt;
      hold_cnt_r <= hold_cnt_nxt;
      len_r      <= len_nxt;
      idx_r      <= idx_nxt;
    end
  end

endmodule

[hdl/md4_core.sv]
// MD4 back end: 48-step compression, one step per cycle (the first round stalls
// on an empty queue), chaining add and four-word digest. Depends on md4_pkg.
module md4_core import md4_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        word_valid,
  input  md4_word_t   word_in,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_last_word
);

  back_state_t state_r, state_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [1:0]  oidx_r, oidx_nxt;
  logic        last_blk_r, last_blk_nxt;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt;
  logic [31:0] chain_r [4];
  logic [31:0] chain_nxt [4];
  logic [31:0] blk_r [16];

  logic        load_phase;
  logic        step_en;
  logic [31:0] x_word;
  logic [31:0] t_sum;
  logic [31:0] t_rot;

  // The first round reads words in arrival order, so it consumes them straight
  // from the queue while they are stored for the two later rounds.
  assign load_phase = (step_r[5:4] == 2'd0);
  assign x_word     = load_phase ? word_in.data : blk_r[msg_index(step_r)];
  assign t_sum      = a_r + round_fn(step_r, b_r, c_r, d_r) + x_word + round_const(step_r);
  assign t_rot      = rotl(t_sum, rot_amount(step_r));

  assign out_valid       = (state_r == B_OUT);
  assign out_digest_word = chain_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == LAST_DIGEST);

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    oidx_nxt     = oidx_r;
    last_blk_nxt = last_blk_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    c_nxt        = c_r;
    d_nxt        = d_r;
    chain_nxt    = chain_r;
    pop          = 1'b0;
    step_en      = 1'b0;
    case (state_r)
      B_RUN: begin
        step_en = !load_phase || word_valid;
        pop     = load_phase && word_valid;
        if (pop && step_r[3:0] == LAST_LOAD) begin
          last_blk_nxt = word_in.last_blk;
        end
        if (step_en) begin
          a_nxt = d_r;
          d_nxt = c_r;
          c_nxt = b_r;
          b_nxt = t_rot;
          if (step_r == LAST_STEP) begin
            step_nxt  = '0;
            state_nxt = B_ADD;
          end else begin
            step_nxt = step_r + 6'd1;
          end
        end
      end
      B_ADD: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        a_nxt        = chain_nxt[0];
        b_nxt        = chain_nxt[1];
        c_nxt        = chain_nxt[2];
        d_nxt        = chain_nxt[3];
        oidx_nxt     = '0;
        state_nxt    = last_blk_r ? B_OUT : B_RUN;
      end
      B_OUT: begin
        if (out_ready) begin
          oidx_nxt = oidx_r + 2'd1;
          if (oidx_r == LAST_DIGEST) begin
            for (int i = 0; i < 4; i++) begin
              chain_nxt[i] = iv_word(2'(i));
            end
            a_nxt     = IV_A;
            b_nxt     = IV_B;
            c_nxt     = IV_C;
            d_nxt     = IV_D;
            state_nxt = B_RUN;
          end
        end
      end
      default: begin
        state_nxt = B_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      blk_r[step_r[3:0]] <= word_in.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_RUN;
      step_r     <= '0;
      oidx_r     <= '0;
      last_blk_r <= 1'b0;
      a_r        <= IV_A;
      b_r        <= IV_B;
      c_r        <= IV_C;
      d_r        <= IV_D;
      for (int i = 0; i < 4; i++) begin
        chain_r[i] <= iv_word(2'(i));
      end
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      oidx_r     <= oidx_nxt;
      last_blk_r <= last_blk_nxt;
      a_r        <= a_nxt;
      b_r        <= b_nxt;
      c_r        <= c_nxt;
      d_r        <= d_nxt;
      chain_r    <= chain_nxt;
    end
  end

endmodule

[hdl/md4_hash_top.sv]
// MD4 digest engine. Each 16-word block runs 48 steps at one step per cycle,
// stalling when the first round finds the queue empty, plus one chaining add.
// The first digest word leaves after the chaining add of the message's last
// block, a second padding block where the length does not fit in the first;
// the other three follow one per cycle while out_ready is high.
// Reset: synchronous, active low; chaining, length, packing and queue clear.
module md4_hash_top import md4_pkg::*; #(
  parameter int FIFO_DEPTH_P = FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_last_word
);

  // The front end packs bytes into whole words and, after the final input word,
  // produces the 0x80 pad word, zero words and the two length words. Each queued
  // word carries a flag that is set only on the upper length word, which is the
  // sixteenth word of the message's last block.
  md4_word_t push_word;
  md4_word_t head_word;
  logic      push;
  logic      pop;
  logic      fifo_full;
  logic      fifo_not_empty;

  md4_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_word (in_data_word),
    .in_byte_count(in_byte_count),
    .in_last_item (in_last_item),
    .push         (push),
    .push_word    (push_word),
    .fifo_full    (fifo_full)
  );

  // The queue lets the front end keep accepting words while the core works
  // through the later rounds of a block or waits on the digest output.
  md4_fifo #(
    .DEPTH(FIFO_DEPTH_P)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_word(push_word),
    .full     (fifo_full),
    .pop      (pop),
    .head     (head_word),
    .not_empty(fifo_not_empty)
  );

  // The core runs the first round directly on queued words as they arrive,
  // so loading a block overlaps its compression.
  md4_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .word_valid     (fifo_not_empty),
    .word_in        (head_word),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digest_word(out_digest_word),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word)
  );

endmodule

[tb/sv/md4_checker.sv]
// Scoreboard for the MD4 digest engine: watches both channels, models the digest
// for every accepted word and compares each digest word as it leaves the block.
// Depends on nothing but the port widths of md4_hash_top.
module md4_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_item,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_digest_word,
  input  logic [1:0]  out_word_index,
  input  logic        out_last_word,
  output int          error_count,
  output int          owed_words,
  output int          words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [31:0] ROUND2_ADD = 32'h5A827999;
  localparam logic [31:0] ROUND3_ADD = 32'h6ED9EBA1;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam int          REPORT_MAX = 10;
  localparam int          ROT_BY_STEP [12] = '{3, 7, 11, 19, 3, 5, 9, 13, 3, 9, 11, 15};

  typedef struct {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } digest_word_t;

  digest_word_t digest_queue[$];

  logic [31:0] chain_abcd [4];
  logic [31:0] block_buf [16];
  int unsigned fill_bytes;
  logic [63:0] msg_bits;
  int          errors;
  int          reported;
  int          checked;

  task automatic restart_chain();
    chain_abcd[0] = INIT_A;
    chain_abcd[1] = INIT_B;
    chain_abcd[2] = INIT_C;
    chain_abcd[3] = INIT_D;
    fill_bytes = 0;
    msg_bits = '0;
  endtask

  task automatic compress_block();
    logic [31:0] a, b, c, d, f, k, t;
    int rnd, j, w, sh;
    a = chain_abcd[0];
    b = chain_abcd[1];
    c = chain_abcd[2];
    d = chain_abcd[3];
    for (int i = 0; i < 48; i++) begin
      rnd = i / 16;
      j = i % 16;
      if (rnd == 0) begin
        w = j;
        f = (b & c) | (~b & d);
        k = '0;
      end else if (rnd == 1) begin
        // Second round walks the block column by column.
        w = (j % 4) * 4 + j / 4;
        f = (b & c) | (b & d) | (c & d);
        k = ROUND2_ADD;
      end else begin
        // Third round takes the words in bit-reversed index order.
        w = ((j & 1) << 3) | ((j & 2) << 1) | ((j & 4) >> 1) | ((j & 8) >> 3);
        f = b ^ c ^ d;
        k = ROUND3_ADD;
      end
      sh = ROT_BY_STEP[rnd * 4 + (j % 4)];
      t = a + f + block_buf[w] + k;
      t = (t << sh) | (t >> (32 - sh));
      a = d;
      d = c;
      c = b;
      b = t;
    end
    chain_abcd[0] = chain_abcd[0] + a;
    chain_abcd[1] = chain_abcd[1] + b;
    chain_abcd[2] = chain_abcd[2] + c;
    chain_abcd[3] = chain_abcd[3] + d;
  endtask

  task automatic push_byte(input logic [7:0] v);
    block_buf[fill_bytes >> 2][8 * (fill_bytes & 3) +: 8] = v;
    fill_bytes++;
    if (fill_bytes == 64) begin
      compress_block();
      fill_bytes = 0;
    end
  endtask

  task automatic absorb_word(input logic [31:0] data, input logic [2:0] count,
                             input logic last);
    int unsigned n;
    logic [63:0] add_bits;
    digest_word_t e;
    // Counts above four still mean a full word.
    n = (count > 3'd4) ? 4 : int'(count);
    for (int i = 0; i < n; i++) push_byte(data[8 * i +: 8]);
    add_bits = 64'(n * 8);
    if (msg_bits > ~add_bits) msg_bits = '1;
    else msg_bits = msg_bits + add_bits;
    if (last) begin
      push_byte(PAD_MARK);
      while (fill_bytes != 56) push_byte(8'h00);
      block_buf[14] = msg_bits[31:0];
      block_buf[15] = msg_bits[63:32];
      compress_block();
      for (int i = 0; i < 4; i++) begin
        e.digest_word = chain_abcd[i];
        e.word_index  = 2'(i);
        e.last_word   = (i == 3);
        digest_queue.push_back(e);
      end
      restart_chain();
    end
  endtask

  always @(posedge clk) begin : watch
    digest_word_t e;
    if (!rst_n) begin
      restart_chain();
      for (int i = 0; i < 16; i++) block_buf[i] = '0;
      digest_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (digest_queue.size() == 0) begin
          errors++;
          if (reported < REPORT_MAX) begin
            reported++;
            $display("[%0t] unexpected digest word %h index %0d last %0b", $realtime,
                     out_digest_word, out_word_index, out_last_word);
          end
        end else begin
          e = digest_queue.pop_front();
          checked++;
          if (out_digest_word !== e.digest_word || out_word_index !== e.word_index ||
              out_last_word !== e.last_word) begin
            errors++;
            if (reported < REPORT_MAX) begin
              reported++;
              $display("[%0t] digest mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                       $realtime, e.digest_word, e.word_index, e.last_word,
                       out_digest_word, out_word_index, out_last_word);
            end
          end
        end
      end
      if (in_valid && in_ready) absorb_word(in_data_word, in_byte_count, in_last_item);
    end
    error_count   <= errors;
    owed_words    <= digest_queue.size();
    words_checked <= checked;
  end

  initial begin
    errors = 0;
    reported = 0;
    checked = 0;
    error_count = 0;
    owed_words = 0;
    words_checked = 0;
    restart_chain();
  end

endmodule

[tb/sv/tb_md4_hash_top.sv]
// Top of the MD4 digest engine testbench: drives message words into md4_hash_top,
// throttles the digest channel and reports the verdict. Needs md4_checker and the RTL.
module tb_md4_hash_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Number of random message words to send after the directed messages.
  localparam int RANDOM_WORDS = 230;
  // Percentage of cycles in which either side holds back.
  localparam int IDLE_PCT = 28;
  // Cycles allowed for the last digest to come out once the sender is done.
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_data_word = '0;
  logic [2:0]  in_byte_count = '0;
  logic        in_last_item = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [1:0]  out_word_index;
  logic        out_last_word;

  int error_count;
  int owed_words;
  int words_checked;

  // While calm is set neither side idles, so the block runs back to back.
  logic calm = 1'b0;
  int   words_sent = 0;
  int   messages_sent = 0;

  md4_hash_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_word    (in_data_word),
    .in_byte_count   (in_byte_count),
    .in_last_item    (in_last_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  md4_checker scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_word    (in_data_word),
    .in_byte_count   (in_byte_count),
    .in_last_item    (in_last_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word),
    .error_count     (error_count),
    .owed_words      (owed_words),
    .words_checked   (words_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The digest side stalls at random, except during the calm stretch.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Offers one word and returns at the edge where it is taken. Idle cycles are
  // inserted before the word, so valid is only ever lowered between words.
  task automatic send_word(input logic [31:0] data, input logic [2:0] count,
                           input logic last);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_data_word  <= data;
    in_byte_count <= count;
    in_last_item  <= last;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (last) messages_sent++;
  endtask

  // Holds the sender back until every digest word owed so far has come out.
  // The first edge lets the scoreboard catch up with the word just taken.
  task automatic drain_digests();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_words != 0);
  endtask

  // A message of random length: mostly full words, now and then a partial or
  // empty word in the middle, and a closing word of any byte count.
  task automatic send_random_message(output int n_words);
    int len;
    logic [2:0] cnt;
    if ($urandom_range(99) < 85) len = $urandom_range(1, 20);
    else len = $urandom_range(21, 40);
    for (int i = 0; i < len; i++) begin
      if (i == len - 1) cnt = 3'($urandom_range(0, 7));
      else if ($urandom_range(99) < 80) cnt = 3'd4;
      else cnt = 3'($urandom_range(0, 7));
      send_word($urandom, cnt, i == len - 1);
    end
    n_words = len;
  endtask

  initial begin : stimulus
    int rand_words;
    int n;
    int waited;
    bit paused;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty message: a lone closing word with no bytes.
    send_word(32'hDEADBEEF, 3'd0, 1'b1);
    // One full word of all ones, then one of zeros with an oversized count.
    send_word(32'hFFFFFFFF, 3'd4, 1'b1);
    send_word(32'h00000000, 3'd7, 1'b1);
    // Counts of five and six also mean four bytes.
    send_word(32'h12345678, 3'd5, 1'b0);
    send_word(32'h9ABCDEF0, 3'd6, 1'b1);
    // Partial and empty words in the middle pack tightly at byte level.
    send_word(32'hA5A5A5A5, 3'd1, 1'b0);
    send_word(32'h5A5A5A5A, 3'd2, 1'b0);
    send_word(32'hC3C3C3C3, 3'd3, 1'b0);
    send_word(32'h0F0F0F0F, 3'd0, 1'b0);
    send_word(32'hF0F0F0F0, 3'd3, 1'b1);
    // Fifty-six bytes leave no room for the length, so padding spills into a
    // second block.
    for (int i = 0; i < 14; i++) begin
      send_word({4{8'(i * 17)}} ^ 32'h3C96_5AA5, 3'd4, i == 13);
    end
    drain_digests();

    rand_words = 0;
    paused = 1'b0;
    while (rand_words < RANDOM_WORDS) begin
      calm <= (rand_words >= 60 && rand_words < 140);
      send_random_message(n);
      rand_words += n;
      if (!paused && rand_words >= RANDOM_WORDS / 2) begin
        paused = 1'b1;
        drain_digests();
      end
    end
    calm <= 1'b0;
    in_valid <= 1'b0;

    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (owed_words != 0 && waited < DRAIN_LIMIT);

    if (owed_words != 0) begin
      $display("Digest words still outstanding after %0d cycles: %0d", waited, owed_words);
      $display("TEST FAILED");
      $finish;
    end else begin
      repeat (SETTLE_CYCLES) @(posedge clk);
      $display("Hashed %0d messages from %0d words, with partial, empty and oversized counts.",
               messages_sent, words_sent);
      $display("Compared %0d digest words, %0d errors.", words_checked, error_count);
      if (error_count == 0) begin
        $display("TEST PASSED");
      end else begin
        $display("TEST FAILED");
      end
      $finish;
    end
  end

  // Hard stop far beyond the slowest legal run.
  initial begin : watchdog
    #2ms;
    $display("Simulation time limit reached.");
    $display("TEST FAILED");
    $finish;
  end

endmodule
